// File: sv/att_pkg.sv
`timescale 1ns / 1ps

package att_pkg;

	// input word field widths
	localparam int DELAY_W = 31;
	localparam int EVENT_W = 8;
	localparam int AUX_W   = 32;
	localparam int TIME_W  = 32;

	// result word field widths
	localparam int KIND_W   = 2;
	localparam int ACTIVE_W = 3;

	// at most this many alarms fire on one tick
	localparam int MAX_OUT = 4;
	localparam int NOUT_W  = 3;

	// operation codes
	localparam logic OP_REQ  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_DONE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE_DUE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

	// one slot of the alarm table, as held in memory
	typedef struct packed {
		logic               periodic;
		logic [EVENT_W-1:0] event_id;
		logic [AUX_W-1:0]   aux;
		logic [DELAY_W-1:0] reload;
		logic [TIME_W-1:0]  due;
	} slot_entry_t;

	// one result word
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [EVENT_W-1:0]  fired_event;
		logic [AUX_W-1:0]    fired_aux;
		logic                last;
		logic [ACTIVE_W-1:0] active_count;
	} res_word_t;

endpackage

// File: sv/att_req_if.sv
`timescale 1ns / 1ps

interface att_req_if;
	import att_pkg::*;

	logic               valid;
	logic               ready;
	logic               operation;
	logic [DELAY_W-1:0] delay_ms;
	logic               periodic;
	logic [EVENT_W-1:0] event_id;
	logic [AUX_W-1:0]   aux_data;
	logic [TIME_W-1:0]  now_ms;

	modport source (
		output valid, operation, delay_ms, periodic, event_id, aux_data, now_ms,
		input  ready
	);

	modport sink (
		input  valid, operation, delay_ms, periodic, event_id, aux_data, now_ms,
		output ready
	);

endinterface

// File: sv/att_res_if.sv
`timescale 1ns / 1ps

interface att_res_if;
	import att_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [EVENT_W-1:0]  fired_event;
	logic [AUX_W-1:0]    fired_aux;
	logic                last;
	logic [ACTIVE_W-1:0] active_count;

	modport source (
		output valid, kind, fired_event, fired_aux, last, active_count,
		input  ready
	);

	modport sink (
		input  valid, kind, fired_event, fired_aux, last, active_count,
		output ready
	);

endinterface

// File: sv/alarm_timer_table.sv
`timescale 1ns / 1ps

// Channel   Modport   Word
// req       sink      request or tick: operation, delay_ms, periodic, event_id, aux_data, now_ms
// res       source    result: kind, fired_event, fired_aux, last, active_count
//
// One word is taken at a time. The slot memory is scanned one slot per cycle while the scan
// is not stalled, with the read pipelined one ahead through the single read port; the next
// word is taken only once the last result of the previous one has been registered.
// Reset clears the active marks and the alarm count; the memory itself is not cleared.
// A stalled result port holds the scan only when a second fired alarm is found while
// the previous one is still waiting; a finished result waits in the output register.

module alarm_timer_table
	import att_pkg::*;
#(
	parameter int SLOTS = 4
) (
	input logic        clk,
	input logic        arst_n,
	att_req_if.sink    req,
	att_res_if.source  res
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	// control state
	logic [1:0]        state_q;
	logic [CW-1:0]     idx_rd_q;
	logic              v_s1;
	logic [IW-1:0]     idx_s1;
	logic [SLOTS-1:0]  active_q;
	logic [CW-1:0]     count_q;
	logic [NOUT_W-1:0] n_q;
	logic              found_q;
	logic              pend_v_q;
	logic              out_valid_q;

	// captured request word
	logic               op_q;
	logic [DELAY_W-1:0] delay_q;
	logic               per_q;
	logic [EVENT_W-1:0] ev_q;
	logic [AUX_W-1:0]   aux_q;
	logic [TIME_W-1:0]  now_q;

	// slot memory and its read register
	slot_entry_t slot_mem_q [SLOTS];
	slot_entry_t rd_q;

	res_word_t pend_q;
	res_word_t out_q;

	// combinational control
	logic              rd_en;
	logic              act_s1;
	logic              hit_tick;
	logic              hit_req;
	logic              push_ok;
	logic              stall;
	logic              push;
	res_word_t         out_d;
	logic              mem_we;
	logic [IW-1:0]     mem_wa;
	slot_entry_t       mem_wd;
	slot_entry_t       fill;
	logic              act_clr;
	logic              act_set;
	logic [IW-1:0]     act_idx;
	logic              cnt_inc;
	logic              cnt_dec;
	logic              pend_load;
	res_word_t         pend_d;
	logic              any_free;
	logic [IW-1:0]     free_idx;

	assign req.ready = (state_q == S_IDLE);

	assign res.valid        = out_valid_q;
	assign res.kind         = out_q.kind;
	assign res.fired_event  = out_q.fired_event;
	assign res.fired_aux    = out_q.fired_aux;
	assign res.last         = out_q.last;
	assign res.active_count = out_q.active_count;

	// lowest free slot
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				any_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// entry written by a set request
	always_comb begin
		fill.periodic = per_q;
		fill.event_id = ev_q;
		fill.aux      = aux_q;
		fill.reload   = delay_q;
		fill.due      = now_q + {1'b0, delay_q};
	end

	// slot evaluation and result selection
	always_comb begin
		act_s1   = active_q[idx_s1];
		hit_tick = v_s1 && (op_q == OP_TICK) && act_s1 && (rd_q.due <= now_q)
			&& (n_q < NOUT_W'(MAX_OUT));
		hit_req  = v_s1 && (op_q == OP_REQ) && act_s1 && (rd_q.event_id == ev_q)
			&& !found_q;
		push_ok  = !out_valid_q || res.ready;
		stall    = hit_tick && pend_v_q && !push_ok;
		rd_en    = (state_q == S_SCAN) && (idx_rd_q < SLOTS_C) && !stall;

		push      = 1'b0;
		out_d     = '0;
		mem_we    = 1'b0;
		mem_wa    = idx_s1;
		mem_wd    = fill;
		act_clr   = 1'b0;
		act_set   = 1'b0;
		act_idx   = idx_s1;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		pend_load = 1'b0;
		pend_d    = '0;

		if (state_q == S_SCAN) begin
			if (hit_tick && !stall) begin
				// the previous fired alarm goes out, this one is held back
				if (pend_v_q) begin
					push  = 1'b1;
					out_d = pend_q;
				end
				pend_load          = 1'b1;
				pend_d.kind        = KIND_FIRED;
				pend_d.fired_event = rd_q.event_id;
				pend_d.fired_aux   = rd_q.aux;
				if (!rd_q.periodic) begin
					act_clr             = 1'b1;
					cnt_dec             = 1'b1;
					pend_d.active_count = ACTIVE_W'(count_q - CW'(1));
				end else begin
					mem_we              = 1'b1;
					mem_wd              = rd_q;
					mem_wd.due          = {1'b0, rd_q.reload} + now_q;
					pend_d.active_count = ACTIVE_W'(count_q);
				end
			end
			if (hit_req) begin
				if (delay_q != '0) begin
					mem_we = 1'b1;
				end else begin
					act_clr = 1'b1;
					cnt_dec = 1'b1;
				end
			end
		end else if (state_q == S_FIN && push_ok) begin
			push       = 1'b1;
			out_d.last = 1'b1;
			if (op_q == OP_TICK) begin
				if (pend_v_q) begin
					out_d      = pend_q;
					out_d.last = 1'b1;
				end else begin
					out_d.kind         = KIND_NONE_DUE;
					out_d.active_count = ACTIVE_W'(count_q);
				end
			end else if (found_q || delay_q == '0) begin
				out_d.kind         = KIND_DONE;
				out_d.active_count = ACTIVE_W'(count_q);
			end else if (any_free) begin
				mem_we             = 1'b1;
				mem_wa             = free_idx;
				act_set            = 1'b1;
				act_idx            = free_idx;
				cnt_inc            = 1'b1;
				out_d.kind         = KIND_DONE;
				out_d.active_count = ACTIVE_W'(count_q + CW'(1));
			end else begin
				out_d.kind         = KIND_OVERFLOW;
				out_d.active_count = ACTIVE_W'(count_q);
			end
		end
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_rd_q    <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			active_q    <= '0;
			count_q     <= '0;
			n_q         <= '0;
			found_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q  <= S_SCAN;
						idx_rd_q <= '0;
						v_s1     <= 1'b0;
						n_q      <= '0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (!stall) begin
						v_s1   <= rd_en;
						idx_s1 <= idx_rd_q[IW-1:0];
					end
					if (rd_en) begin
						idx_rd_q <= idx_rd_q + CW'(1);
					end
					if (hit_req) begin
						found_q <= 1'b1;
					end
					if (pend_load) begin
						pend_v_q <= 1'b1;
						n_q      <= n_q + NOUT_W'(1);
					end
					if (idx_rd_q == SLOTS_C && !v_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (push_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (act_clr) begin
				active_q[act_idx] <= 1'b0;
			end else if (act_set) begin
				active_q[act_idx] <= 1'b1;
			end

			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec && count_q != '0) begin
				count_q <= count_q - CW'(1);
			end

			// output register
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q    <= req.operation;
			delay_q <= req.delay_ms;
			per_q   <= req.periodic;
			ev_q    <= req.event_id;
			aux_q   <= req.aux_data;
			now_q   <= req.now_ms;
		end
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (push) begin
			out_q <= out_d;
		end
	end

	// slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_q <= slot_mem_q[idx_rd_q[IW-1:0]];
		end
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import att_pkg::*;

	localparam int SLOTS       = 4;
	localparam int N_DIR       = 24;
	localparam int RAND_WORDS  = 85;	// per idling phase
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	// one request or tick word as offered on the request channel
	typedef struct packed {
		logic               op;
		logic [DELAY_W-1:0] delay;
		logic               periodic;
		logic [EVENT_W-1:0] ev;
		logic [AUX_W-1:0]   aux;
		logic [TIME_W-1:0]  now;
	} alarm_req_t;

	// directed row: a word, plus a typed-in single result where it is obvious
	typedef struct {
		alarm_req_t        w;
		bit                typed;
		logic [KIND_W-1:0] kind;
		logic [2:0]        cnt;
	} dir_row_t;

	logic clk;
	logic arst_n;

	att_req_if req ();
	att_res_if res ();

	alarm_timer_table #(.SLOTS(SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	// shadow copy of the alarm table
	logic               tbl_active   [SLOTS];
	logic               tbl_periodic [SLOTS];
	logic [EVENT_W-1:0] tbl_event    [SLOTS];
	logic [AUX_W-1:0]   tbl_aux      [SLOTS];
	logic [DELAY_W-1:0] tbl_reload   [SLOTS];
	logic [TIME_W-1:0]  tbl_due      [SLOTS];
	int                 tbl_count;

	res_word_t awaited_results [$];
	dir_row_t  dir_tab [N_DIR];

	int   tx_idle_pct;
	int   rx_idle_pct;
	int   phase;
	logic hold_rx;
	int   cycles;
	int   n_errors, n_results, n_ticks, n_sets, n_cancels, n_fired, n_overflow;
	logic [TIME_W-1:0] clock_ms;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset, once
	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("[alarm_timer_table] ERROR");
				$finish;
			end
		end
	end

	// work out the result words of one accepted word, updating the shadow table
	function automatic int predict_alarms(input alarm_req_t w, output res_word_t r [MAX_OUT]);
		int i;
		int n;
		int hit;
		logic [KIND_W-1:0] k;
		n   = 0;
		hit = -1;
		k   = KIND_DONE;
		for (i = 0; i < MAX_OUT; i++)
			r[i] = '0;
		if (w.op == OP_TICK) begin
			// scan in index order, at most MAX_OUT alarms fire
			for (i = 0; i < SLOTS && n < MAX_OUT; i++) begin
				if (tbl_active[i] && tbl_due[i] <= w.now) begin
					if (!tbl_periodic[i]) begin
						tbl_active[i] = 1'b0;
						if (tbl_count > 0)
							tbl_count--;
					end else begin
						tbl_due[i] = TIME_W'(tbl_reload[i]) + w.now;
					end
					r[n] = '{KIND_FIRED, tbl_event[i], tbl_aux[i], 1'b0, ACTIVE_W'(tbl_count)};
					n++;
				end
			end
			if (n == 0) begin
				r[0] = '{KIND_NONE_DUE, 8'd0, 32'd0, 1'b0, ACTIVE_W'(tbl_count)};
				n = 1;
			end
			r[n-1].last = 1'b1;
			return n;
		end
		// an active slot with the same id is the target of both set and cancel
		for (i = 0; i < SLOTS; i++)
			if (hit < 0 && tbl_active[i] && tbl_event[i] == w.ev)
				hit = i;
		if (w.delay == '0) begin
			if (hit >= 0) begin
				tbl_active[hit] = 1'b0;
				if (tbl_count > 0)
					tbl_count--;
			end
		end else begin
			if (hit < 0 && tbl_count < SLOTS) begin
				for (i = 0; i < SLOTS; i++)
					if (hit < 0 && !tbl_active[i])
						hit = i;
				if (hit >= 0)
					tbl_count++;
			end
			if (hit < 0) begin
				k = KIND_OVERFLOW;
			end else begin
				tbl_active[hit] = 1'b1;
				tbl_event[hit]  = w.ev;
				tbl_aux[hit]    = w.aux;
				tbl_due[hit]    = w.now + TIME_W'(w.delay);
				tbl_periodic[hit] = w.periodic;
				// a one-shot set leaves the reload as it was
				if (w.periodic)
					tbl_reload[hit] = w.delay;
			end
		end
		r[0] = '{k, 8'd0, 32'd0, 1'b1, ACTIVE_W'(tbl_count)};
		return 1;
	endfunction

	// offer one word, wait for it to be taken, then record what it should give
	task automatic send_word(input alarm_req_t w, input bit typed,
			input logic [KIND_W-1:0] kind, input logic [2:0] cnt);
		res_word_t r [MAX_OUT];
		int n;
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= w.op;
		req.delay_ms  <= w.delay;
		req.periodic  <= w.periodic;
		req.event_id  <= w.ev;
		req.aux_data  <= w.aux;
		req.now_ms    <= w.now;
		do @(posedge clk); while (!req.ready);

		n = predict_alarms(w, r);
		if (w.op == OP_TICK)
			n_ticks++;
		else if (w.delay == '0)
			n_cancels++;
		else
			n_sets++;
		for (int i = 0; i < n; i++) begin
			if (r[i].kind == KIND_FIRED)
				n_fired++;
			if (r[i].kind == KIND_OVERFLOW)
				n_overflow++;
		end
		if (typed)
			awaited_results.push_back('{kind, 8'd0, 32'd0, 1'b1, cnt});
		else
			for (int i = 0; i < n; i++)
				awaited_results.push_back(r[i]);
	endtask

	// random word: mostly ids from a small pool so that sets and cancels hit
	function automatic alarm_req_t random_word();
		alarm_req_t w;
		logic [EVENT_W-1:0] pool [6];
		int sel;
		pool = '{8'h00, 8'h11, 8'h42, 8'h80, 8'hC3, 8'hFF};
		w = '0;
		w.aux = $urandom;
		w.periodic = 1'($urandom_range(1));
		w.ev = ($urandom_range(99) < 85) ? pool[$urandom_range(5)] : 8'($urandom_range(255));
		sel = $urandom_range(99);
		if (sel < 45) begin
			w.op = OP_TICK;
			clock_ms = clock_ms + 32'($urandom_range(1, 60));
			w.now = ($urandom_range(99) < 5) ? 32'($urandom) : clock_ms;
		end else begin
			w.op  = OP_REQ;
			w.now = clock_ms;
			if (sel < 85) begin
				w.delay = ($urandom_range(99) < 10) ? DELAY_W'($urandom)
					: DELAY_W'($urandom_range(1, 120));
				if (w.delay == '0)
					w.delay = 1;
			end
		end
		return w;
	endfunction

	// receiver: random stalls, plus one long hold-off
	initial begin
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n || hold_rx)
				res.ready <= 1'b0;
			else
				res.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		hold_rx = 1'b0;
		wait (phase == 2);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// result checker
	always @(posedge clk) begin : check_results
		res_word_t got;
		res_word_t want;
		if (arst_n && res.valid && res.ready) begin
			got = {res.kind, res.fired_event, res.fired_aux, res.last, res.active_count};
			n_results++;
			if (awaited_results.size() == 0) begin
				$error("result word with none expected: kind %0d event %0h", got.kind,
					got.fired_event);
				n_errors++;
			end else begin
				want = awaited_results.pop_front();
				if (got.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, got.kind);
					n_errors++;
				end
				if (got.fired_event !== want.fired_event) begin
					$error("fired_event: expected %0h, got %0h", want.fired_event,
						got.fired_event);
					n_errors++;
				end
				if (got.fired_aux !== want.fired_aux) begin
					$error("fired_aux: expected %0h, got %0h", want.fired_aux, got.fired_aux);
					n_errors++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, got.last);
					n_errors++;
				end
				if (got.active_count !== want.active_count) begin
					$error("active_count: expected %0d, got %0d", want.active_count,
						got.active_count);
					n_errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		req.valid     <= 1'b0;
		req.operation <= OP_REQ;
		req.delay_ms  <= '0;
		req.periodic  <= 1'b0;
		req.event_id  <= '0;
		req.aux_data  <= '0;
		req.now_ms    <= '0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_active[i]   = 1'b0;
			tbl_periodic[i] = 1'b0;
			tbl_event[i]    = '0;
			tbl_aux[i]      = '0;
			tbl_reload[i]   = '0;
			tbl_due[i]      = '0;
		end
		tbl_count   = 0;
		n_errors    = 0;
		n_results   = 0;
		n_ticks     = 0;
		n_sets      = 0;
		n_cancels   = 0;
		n_fired     = 0;
		n_overflow  = 0;
		clock_ms    = 32'd5000;
		phase       = 0;
		tx_idle_pct = 28;
		rx_idle_pct = 80;

		dir_tab = '{
			// tick on an empty table, cancel on an empty table
			'{'{OP_TICK, 31'd0, 1'b0, 8'h00, 32'h0, 32'h0}, 1'b1, KIND_NONE_DUE, 3'd0},
			'{'{OP_REQ, 31'd0, 1'b0, 8'h05, 32'h0, 32'h0}, 1'b1, KIND_DONE, 3'd0},
			// fill the table, smallest and largest delay, due time wrapping
			'{'{OP_REQ, 31'd1, 1'b0, 8'h00, 32'h0, 32'h0}, 1'b1, KIND_DONE, 3'd1},
			'{'{OP_REQ, 31'h7FFFFFFF, 1'b1, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
				1'b1, KIND_DONE, 3'd2},
			'{'{OP_REQ, 31'd10, 1'b1, 8'h10, 32'hA5A5A5A5, 32'd100}, 1'b1, KIND_DONE, 3'd3},
			'{'{OP_REQ, 31'd5, 1'b0, 8'h20, 32'h12345678, 32'd100}, 1'b1, KIND_DONE, 3'd4},
			// full table: new id overflows, known id still rewrites
			'{'{OP_REQ, 31'd3, 1'b0, 8'h30, 32'hDEADBEEF, 32'd100}, 1'b1, KIND_OVERFLOW, 3'd4},
			'{'{OP_REQ, 31'd20, 1'b1, 8'h10, 32'h5A5A5A5A, 32'd100}, 1'b1, KIND_DONE, 3'd4},
			// mixed one-shot and periodic expiry
			'{'{OP_TICK, 31'd0, 1'b0, 8'h00, 32'h0, 32'd200}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_TICK, 31'd0, 1'b0, 8'h00, 32'h0, 32'hFFFFFFFF}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_REQ, 31'd0, 1'b0, 8'h10, 32'h0, 32'd300}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_REQ, 31'd0, 1'b0, 8'h77, 32'h0, 32'd300}, 1'b0, KIND_DONE, 3'd0},
			// four due at once
			'{'{OP_REQ, 31'd1, 1'b1, 8'h01, 32'h1, 32'h0}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_REQ, 31'd2, 1'b1, 8'h02, 32'h2, 32'h0}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_REQ, 31'd3, 1'b1, 8'h03, 32'h3, 32'h0}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_TICK, 31'd0, 1'b0, 8'h00, 32'h0, 32'hFFFFFFFF}, 1'b0, KIND_DONE, 3'd0},
			// periodic turned one-shot keeps its old reload
			'{'{OP_REQ, 31'd50, 1'b0, 8'h01, 32'hCAFEF00D, 32'd1000}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_TICK, 31'd0, 1'b0, 8'h00, 32'h0, 32'd1000}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_TICK, 31'd0, 1'b0, 8'h00, 32'h0, 32'd1050}, 1'b0, KIND_DONE, 3'd0},
			// cancel everything, including an id already gone
			'{'{OP_REQ, 31'd0, 1'b0, 8'hFF, 32'h0, 32'd1100}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_REQ, 31'd0, 1'b0, 8'h02, 32'h0, 32'd1100}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_REQ, 31'd0, 1'b0, 8'h03, 32'h0, 32'd1100}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_REQ, 31'd0, 1'b0, 8'h01, 32'h0, 32'd1100}, 1'b0, KIND_DONE, 3'd0},
			'{'{OP_TICK, 31'd0, 1'b0, 8'h00, 32'h0, 32'hFFFFFFFF}, 1'b1, KIND_NONE_DUE, 3'd0}
		};

		// wait for the first edge with reset released
		do @(posedge clk); while (arst_n !== 1'b1);

		// directed rows
		for (int i = 0; i < N_DIR; i++)
			send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].kind, dir_tab[i].cnt);

		// random words over three idling phases
		for (int p = 0; p < 3; p++) begin
			if (p == 1) begin
				tx_idle_pct = 80;
				rx_idle_pct <= 28;
			end else if (p == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
				phase <= 2;
			end
			for (int i = 0; i < RAND_WORDS; i++)
				send_word(random_word(), 1'b0, KIND_DONE, 3'd0);
		end
		req.valid <= 1'b0;

		// drain, then wait on for anything stray
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		$display("Sent %0d words: %0d ticks, %0d sets, %0d cancels.",
			n_ticks + n_sets + n_cancels, n_ticks, n_sets, n_cancels);
		$display("Checked %0d result words: %0d fired alarms, %0d overflow rejections.",
			n_results, n_fired, n_overflow);
		if (n_errors == 0)
			$display("[alarm_timer_table] OK");
		else
			$display("[alarm_timer_table] ERROR");
		$finish;
	end

endmodule
